// ----- rtl/ile_pkg.sv -----
// Package for the indexed list engine: request codes, sequencer states and the
// command struct broadcast to the storage cells. No dependencies.
package ile_pkg;

  localparam int CAP_DEF  = 256;  // default list capacity
  localparam int GROUP_W  = 16;   // cells per registered read-reduction group
  localparam int AT_W     = 13;   // index width, covers the largest capacity (4096)
  localparam int DATA_W   = 32;
  localparam int POS_W    = 10;
  localparam int COUNT_W  = 9;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_WRITE  = 3'd3;
  localparam logic [2:0] REQ_DELETE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESULT
  } ile_state_t;

  // Command seen by every cell in the execute cycle.
  typedef struct packed {
    logic                     shift_up;  // open a slot at 'at'
    logic                     shift_dn;  // close the slot at 'at'
    logic                     load;      // overwrite the cell at 'at'
    logic [AT_W-1:0]          at;
    logic signed [DATA_W-1:0] value;
  } ile_cmd_t;

endpackage

// ----- rtl/ile_cell.sv -----
// One storage cell of the list chain: holds one element, takes its left or
// right neighbor on a shift. Depends on ile_pkg.
module ile_cell
  import ile_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  ile_cmd_t                 cmd,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] sel_data
);

  localparam logic [AT_W-1:0] IDX = AT_W'(INDEX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     here;

  assign here = (cmd.at == IDX);

  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up) begin
      if (here) begin
        data_nxt = cmd.value;
      end else if (IDX > cmd.at) begin
        data_nxt = left_data;
      end
    end else if (cmd.shift_dn) begin
      if (IDX >= cmd.at) begin
        data_nxt = right_data;
      end
    end else if (cmd.load && here) begin
      data_nxt = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  // read tap: only the addressed cell contributes to the OR reduction
  assign sel_data = here ? data_r : '0;

endmodule

// ----- rtl/ile_grp.sv -----
// Registered OR reduction over one group of cell read taps.
// Depends on ile_pkg.
module ile_grp
  import ile_pkg::*;
#(
  parameter int N = GROUP_W
) (
  input  logic                       clk,
  input  logic [N-1:0][DATA_W-1:0]   sel,
  output logic [DATA_W-1:0]          grp_data
);

  logic [DATA_W-1:0] grp_r;
  logic [DATA_W-1:0] grp_nxt;

  always_comb begin
    grp_nxt = '0;
    for (int k = 0; k < N; k++) begin
      grp_nxt = grp_nxt | sel[k];
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  assign grp_data = grp_r;

endmodule

// ----- rtl/indexed_list_engine_unit.sv -----
// Indexed list engine top level: sequencer, count register, cell chain and
// read reduction. Depends on ile_pkg, ile_cell and ile_grp.
//
// Usage:
//   A transaction is issued by raising start with in_req_type, in_position
//   and in_value while busy is low; it is taken at that clock edge.
//   Request codes: append, insert at index, read, overwrite, delete.
//   The list lives in a chain of CAPACITY cells. On insert every cell above
//   the slot takes its left neighbor, on delete every cell at or above the
//   slot takes its right neighbor, all in the same execute cycle.
//   The result appears on out_strobe, high for exactly one cycle. The
//   execute state performs the shift/overwrite and registers the per-group
//   read taps; the result state ORs the groups and presents the result.
//   A new request overlaps the previous result. busy is high only in the
//   execute cycle, so a new start may be taken in the cycle that shows the
//   previous result.
//   Every result carries the element count and the empty flag after the
//   request. Reads out of range return -1 with out_hit low; refused
//   appends/inserts on a full list set out_full_res.
//   Reset (rst_n low, synchronous) empties the list and returns to idle;
//   cell contents are not cleared, only positions below the count are ever
//   read. The receiver cannot stall: out_strobe is not held off.
module indexed_list_engine_unit
  import ile_pkg::*;
#(
  parameter int CAPACITY = CAP_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_req_type,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic                     out_hit,
  output logic                     out_full_res,
  output logic [COUNT_W-1:0]       out_element_count,
  output logic                     out_is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NGRP  = (CAPACITY + GROUP_W - 1) / GROUP_W;

  // ---------------- sequencer
  ile_state_t state_r, state_nxt;
  logic       accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   state_nxt = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC:   state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = accept ? ST_EXEC : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  logic exec;
  always_comb begin
    busy       = 1'b0;
    out_strobe = 1'b0;
    exec       = 1'b0;
    unique case (state_r)
      ST_IDLE:   ;
      ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      ST_RESULT: out_strobe = 1'b1;
      default:   ;
    endcase
  end

  // ---------------- request capture
  logic [2:0]               req_type_r;
  logic [POS_W-1:0]         position_r;
  logic signed [DATA_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_req_type;
      position_r <= in_position;
      value_r    <= in_value;
    end
  end

  // ---------------- execute-cycle decode
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AT_W-1:0]  pos_w, cnt_w;
  logic             in_range, is_full;
  logic             hit_c, full_c, rd_c;
  ile_cmd_t         cmd;

  assign pos_w    = AT_W'(position_r);
  assign cnt_w    = AT_W'(cnt_r);
  assign in_range = pos_w < cnt_w;
  assign is_full  = cnt_w == AT_W'(CAPACITY);

  always_comb begin
    cmd          = '0;
    cmd.value    = value_r;
    cmd.at       = pos_w;
    cnt_nxt      = cnt_r;
    hit_c        = 1'b0;
    full_c       = 1'b0;
    rd_c         = 1'b0;
    case (req_type_r) inside
      REQ_APPEND, REQ_INSERT: begin
        if (is_full) begin
          full_c = 1'b1;
        end else begin
          // insert past the end appends
          cmd.at       = (req_type_r == REQ_INSERT && in_range) ? pos_w : cnt_w;
          cmd.shift_up = exec;
          cnt_nxt      = cnt_r + CNT_W'(1);
          hit_c        = 1'b1;
        end
      end
      REQ_READ: begin
        rd_c  = 1'b1;
        hit_c = in_range;
      end
      REQ_WRITE: begin
        hit_c    = in_range;
        cmd.load = exec && in_range;
      end
      REQ_DELETE: begin
        if (in_range) begin
          cmd.shift_dn = exec;
          cnt_nxt      = cnt_r - CNT_W'(1);
          hit_c        = 1'b1;
        end
      end
      default: ;  // unknown codes change nothing
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  // result flags, held for the result cycle
  logic res_hit_r, res_full_r, res_rd_r;
  always_ff @(posedge clk) begin
    if (exec) begin
      res_hit_r  <= hit_c;
      res_full_r <= full_c;
      res_rd_r   <= rd_c;
    end
  end

  // ---------------- cell chain
  logic signed [DATA_W-1:0]         cell_data [CAPACITY];
  logic [NGRP*GROUP_W-1:0][DATA_W-1:0] sel_pad;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [DATA_W-1:0] left_d, right_d, sel_d;
      if (gi == 0) begin : g_first
        assign left_d = value_r;
      end else begin : g_mid
        assign left_d = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = cell_data[gi];
      end else begin : g_body
        assign right_d = cell_data[gi+1];
      end
      ile_cell #(.INDEX(gi)) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_data[gi]),
        .sel_data   (sel_d)
      );
      assign sel_pad[gi] = sel_d;
    end
    for (gi = CAPACITY; gi < NGRP*GROUP_W; gi++) begin : g_pad
      assign sel_pad[gi] = '0;
    end
  endgenerate

  // ---------------- read reduction: registered groups, then final OR
  logic [DATA_W-1:0] grp_data [NGRP];

  generate
    for (gi = 0; gi < NGRP; gi++) begin : g_grp
      ile_grp #(.N(GROUP_W)) u_grp (
        .clk      (clk),
        .sel      (sel_pad[gi*GROUP_W +: GROUP_W]),
        .grp_data (grp_data[gi])
      );
    end
  endgenerate

  logic [DATA_W-1:0] rd_word;
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_data[g];
    end
  end

  // ---------------- result outputs
  always_comb begin
    if (!res_rd_r) begin
      out_read_value = '0;
    end else if (res_hit_r) begin
      out_read_value = $signed(rd_word);
    end else begin
      out_read_value = '1;  // -1: read out of range
    end
  end

  assign out_hit           = res_hit_r;
  assign out_full_res      = res_full_r;
  assign out_element_count = COUNT_W'(cnt_r);
  assign out_is_empty      = (cnt_r == '0);

endmodule

// ----- rtl/ile_checker.sv -----
// Port-level checker for indexed_list_engine_unit, bound to the top level.
// Depends on ile_pkg.
module ile_checker
  import ile_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_strobe,
  input logic                     out_hit,
  input logic                     out_full_res,
  input logic [COUNT_W-1:0]       out_element_count,
  input logic                     out_is_empty
);

  // an accepted transaction occupies the execute cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // result strobe follows acceptance, after the execute state
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result missing two cycles after acceptance");

  // a refused append or insert is never a hit
  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_full_res) |-> !out_hit)
    else $error("full and hit both set");

  // empty list reports zero count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_is_empty) |-> (out_element_count == '0))
    else $error("empty flag with nonzero count");

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_hit           (out_hit),
  .out_full_res      (out_full_res),
  .out_element_count (out_element_count),
  .out_is_empty      (out_is_empty)
);
